// ----- design/dmpcp_pkg.sv -----
// Shared types, byte codes and character mapping for the printer command parser.
package dmpcp_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int OUT_POS_BITS   = 16;

    typedef enum logic [1:0] {
        EV_CHAR   = 2'd0,
        EV_COLUMN = 2'd1,
        EV_EJECT  = 2'd2
    } event_kind_t;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_LEFT_MARGIN  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BOTTOM_LIMIT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LINE_SPACING = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COLUMN_STEP  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHAR_ADVANCE = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOP_OF_PAGE  = 3'd5;

    localparam logic [15:0] LEFT_MARGIN_RST  = 16'd36;
    localparam logic [15:0] BOTTOM_LIMIT_RST = 16'd756;
    localparam logic [11:0] LINE_SPACING_RST = 12'd12;
    localparam logic [4:0]  COLUMN_STEP_RST  = 5'd1;
    localparam logic [6:0]  CHAR_ADVANCE_RST = 7'd6;
    localparam logic [15:0] TOP_OF_PAGE_RST  = 16'd0;

    localparam logic [7:0] BYTE_ESC       = 8'h1B;
    localparam logic [7:0] BYTE_IMAGE_ON  = 8'h08;
    localparam logic [7:0] BYTE_IMAGE_OFF = 8'h0F;
    localparam logic [7:0] BYTE_CR        = 8'h0D;
    localparam logic [7:0] BYTE_FF        = 8'h0C;
    localparam logic [7:0] BYTE_ESC_ON    = 8'h38;
    localparam logic [7:0] BYTE_ESC_OFF   = 8'h37;
    localparam logic [7:0] UPPER_LO       = 8'h41;
    localparam logic [7:0] UPPER_HI       = 8'h5A;
    localparam logic [7:0] SHIFTED_LO     = 8'hC1;
    localparam logic [7:0] SHIFTED_HI     = 8'hDA;
    localparam logic [7:0] SHIFTED_OFFSET = 8'h60;
    localparam logic [7:0] PUNCT_LO       = 8'h20;
    localparam logic [7:0] PUNCT_HI       = 8'h3F;
    localparam logic [6:0] ASCII_SPACE    = 7'h20;

    typedef struct packed {
        event_kind_t           kind;
        logic [6:0]            code;
        logic [6:0]            pins;
        logic [OUT_POS_BITS-1:0] x;
        logic [OUT_POS_BITS-1:0] y;
    } result_t;

    // Shifted letters map down to lower case; anything without a glyph prints a space.
    function automatic logic [6:0] map_code(input logic [7:0] b);
        logic [7:0] shifted;
        shifted = b - SHIFTED_OFFSET;
        if (b >= UPPER_LO && b <= UPPER_HI) begin
            map_code = b[6:0];
        end else if (b >= SHIFTED_LO && b <= SHIFTED_HI) begin
            map_code = shifted[6:0];
        end else if (b >= PUNCT_LO && b <= PUNCT_HI) begin
            map_code = b[6:0];
        end else begin
            map_code = ASCII_SPACE;
        end
    endfunction

endpackage

// ----- design/dot_matrix_printer_command_parser.sv -----
// Printer byte-stream command parser with print head position tracking.
// A result is registered in the output register, or in the skid entry while the output stalls.
// Throughput: one byte per cycle while the skid entry is empty; the head update is one add and compare per byte.
// A skid entry holds one result under output stall; input stalls while it is full.
// Reset: flags clear, registers take their default values, head goes to
// the default left margin and top of page, and no result is pending.
module dot_matrix_printer_command_parser #(
    parameter int POSITION_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [7:0]                            data_byte,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [1:0]                            event_kind,
    output logic [6:0]                            char_code,
    output logic [6:0]                            pin_mask,
    output logic [dmpcp_pkg::OUT_POS_BITS-1:0]    pos_x,
    output logic [dmpcp_pkg::OUT_POS_BITS-1:0]    pos_y,
    input  logic                                  cfg_write_en,
    input  logic [dmpcp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [dmpcp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int PB = POSITION_BITS;

    logic [15:0] left_margin_reg;
    logic [15:0] bottom_limit_reg;
    logic [11:0] line_spacing_reg;
    logic [4:0]  column_step_reg;
    logic [6:0]  char_advance_reg;
    logic [15:0] top_of_page_reg;

    logic          esc_pending_reg;
    logic          esc_pending_next;
    logic          bit_image_reg;
    logic          bit_image_next;
    logic [PB-1:0] head_x_reg;
    logic [PB-1:0] head_x_next;
    logic [PB-1:0] head_y_reg;
    logic [PB-1:0] head_y_next;

    logic                 out_valid_reg;
    dmpcp_pkg::result_t   out_reg;
    logic                 skid_valid_reg;
    dmpcp_pkg::result_t   skid_reg;

    logic                 accept;
    logic                 res_valid;
    dmpcp_pkg::result_t   res;

    logic [PB-1:0] margin_pos;
    logic [PB-1:0] top_pos;
    logic [PB-1:0] bottom_pos;
    logic [PB-1:0] cr_y;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = skid_valid_reg;
    assign margin_pos = PB'(left_margin_reg);
    assign top_pos    = PB'(top_of_page_reg);
    assign bottom_pos = PB'(bottom_limit_reg);
    assign cr_y       = head_y_reg + PB'(line_spacing_reg);

    always_comb
    begin
        esc_pending_next = esc_pending_reg;
        bit_image_next   = bit_image_reg;
        head_x_next      = head_x_reg;
        head_y_next      = head_y_reg;
        res_valid        = 1'b0;
        res.kind         = dmpcp_pkg::EV_CHAR;
        res.code         = 7'd0;
        res.pins         = 7'd0;
        res.x            = dmpcp_pkg::OUT_POS_BITS'(head_x_reg);
        res.y            = dmpcp_pkg::OUT_POS_BITS'(head_y_reg);

        if (esc_pending_reg) begin
            // The byte after ESC is a command and is always consumed.
            esc_pending_next = 1'b0;
            if (data_byte == dmpcp_pkg::BYTE_ESC_ON) begin
                bit_image_next = 1'b1;
            end else if (data_byte == dmpcp_pkg::BYTE_ESC_OFF) begin
                bit_image_next = 1'b0;
            end
        end else if (data_byte == dmpcp_pkg::BYTE_ESC) begin
            esc_pending_next = 1'b1;
        end else if (data_byte == dmpcp_pkg::BYTE_IMAGE_ON) begin
            bit_image_next = 1'b1;
        end else if (data_byte == dmpcp_pkg::BYTE_IMAGE_OFF) begin
            bit_image_next = 1'b0;
        end else if (data_byte == dmpcp_pkg::BYTE_CR) begin
            bit_image_next = 1'b0;
            head_x_next    = margin_pos;
            if (cr_y >= bottom_pos) begin
                head_y_next = top_pos;
                res_valid   = 1'b1;
                res.kind    = dmpcp_pkg::EV_EJECT;
                res.x       = dmpcp_pkg::OUT_POS_BITS'(margin_pos);
                res.y       = dmpcp_pkg::OUT_POS_BITS'(top_pos);
            end else begin
                head_y_next = cr_y;
            end
        end else if (data_byte == dmpcp_pkg::BYTE_FF) begin
            head_x_next = margin_pos;
            head_y_next = top_pos;
            res_valid   = 1'b1;
            res.kind    = dmpcp_pkg::EV_EJECT;
            res.x       = dmpcp_pkg::OUT_POS_BITS'(margin_pos);
            res.y       = dmpcp_pkg::OUT_POS_BITS'(top_pos);
        end else if (bit_image_reg) begin
            head_x_next = head_x_reg + PB'(column_step_reg);
            res_valid   = 1'b1;
            res.kind    = dmpcp_pkg::EV_COLUMN;
            res.pins    = data_byte[6:0];
        end else begin
            head_x_next = head_x_reg + PB'(char_advance_reg);
            res_valid   = 1'b1;
            res.kind    = dmpcp_pkg::EV_CHAR;
            res.code    = dmpcp_pkg::map_code(data_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            left_margin_reg  <= dmpcp_pkg::LEFT_MARGIN_RST;
            bottom_limit_reg <= dmpcp_pkg::BOTTOM_LIMIT_RST;
            line_spacing_reg <= dmpcp_pkg::LINE_SPACING_RST;
            column_step_reg  <= dmpcp_pkg::COLUMN_STEP_RST;
            char_advance_reg <= dmpcp_pkg::CHAR_ADVANCE_RST;
            top_of_page_reg  <= dmpcp_pkg::TOP_OF_PAGE_RST;
        end else if (cfg_write_en) begin
            case (cfg_index)
                dmpcp_pkg::CFG_LEFT_MARGIN:  left_margin_reg  <= cfg_data;
                dmpcp_pkg::CFG_BOTTOM_LIMIT: bottom_limit_reg <= cfg_data;
                dmpcp_pkg::CFG_LINE_SPACING: line_spacing_reg <= cfg_data[11:0];
                dmpcp_pkg::CFG_COLUMN_STEP:  column_step_reg  <= cfg_data[4:0];
                dmpcp_pkg::CFG_CHAR_ADVANCE: char_advance_reg <= cfg_data[6:0];
                dmpcp_pkg::CFG_TOP_OF_PAGE:  top_of_page_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            esc_pending_reg <= 1'b0;
            bit_image_reg   <= 1'b0;
            head_x_reg      <= PB'(dmpcp_pkg::LEFT_MARGIN_RST);
            head_y_reg      <= PB'(dmpcp_pkg::TOP_OF_PAGE_RST);
        end else if (accept) begin
            esc_pending_reg <= esc_pending_next;
            bit_image_reg   <= bit_image_next;
            head_x_reg      <= head_x_next;
            head_y_reg      <= head_y_next;
        end
    end

    // The skid entry only fills while the result register is held by a stall,
    // and input stalls while it is full, so order is kept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || !out_stall) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept && res_valid;
            end
        end else if (accept && res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept && res_valid) begin
                out_reg <= res;
            end
        end else if (accept && res_valid) begin
            skid_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = out_reg.kind;
    assign char_code  = out_reg.code;
    assign pin_mask   = out_reg.pins;
    assign pos_x      = out_reg.x;
    assign pos_y      = out_reg.y;

endmodule

// ----- tb/tb_dot_matrix_printer_command_parser.sv -----
// Self-checking testbench for the printer command parser: random and directed byte streams.
`timescale 1ns / 1ps

module tb_dot_matrix_printer_command_parser;

    localparam int POS_BITS = 16;
    localparam int IDX_BITS = dmpcp_pkg::CFG_INDEX_BITS;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic [7:0]                           data_byte = 8'h00;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic [1:0]                           event_kind;
    logic [6:0]                           char_code;
    logic [6:0]                           pin_mask;
    logic [dmpcp_pkg::OUT_POS_BITS-1:0]   pos_x;
    logic [dmpcp_pkg::OUT_POS_BITS-1:0]   pos_y;
    logic                                 cfg_write_en = 1'b0;
    logic [IDX_BITS-1:0]                  cfg_index = '0;
    logic [dmpcp_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

    dot_matrix_printer_command_parser #(
        .POSITION_BITS(POS_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .event_kind(event_kind),
        .char_code(char_code),
        .pin_mask(pin_mask),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Printer state as the testbench sees it.
    logic                esc_armed;
    logic                image_mode;
    logic [POS_BITS-1:0] head_x;
    logic [POS_BITS-1:0] head_y;
    logic [15:0]         cfg_left;
    logic [15:0]         cfg_bottom;
    logic [11:0]         cfg_spacing;
    logic [4:0]          cfg_step;
    logic [6:0]          cfg_advance;
    logic [15:0]         cfg_top;

    logic [7:0]          pending_bytes[$];
    dmpcp_pkg::result_t  expected_events[$];

    int send_idle_pct = 38;
    int recv_idle_pct = 80;
    int bytes_queued = 0;
    int bytes_accepted = 0;
    int mismatches = 0;
    int chars_seen = 0;
    int columns_seen = 0;
    int ejects_seen = 0;
    int settings_used = 1;

    // Applies one byte to the printer state; returns 1 when the byte yields an event.
    function automatic bit printer_step(input logic [7:0] b, output dmpcp_pkg::result_t ev);
        logic [7:0] lowered;
        ev = '0;
        lowered = b - dmpcp_pkg::SHIFTED_OFFSET;
        if (esc_armed) begin
            esc_armed = 1'b0;
            if (b == dmpcp_pkg::BYTE_ESC_ON) image_mode = 1'b1;
            else if (b == dmpcp_pkg::BYTE_ESC_OFF) image_mode = 1'b0;
            return 1'b0;
        end
        case (b)
            dmpcp_pkg::BYTE_ESC: begin
                esc_armed = 1'b1;
                return 1'b0;
            end
            dmpcp_pkg::BYTE_IMAGE_ON: begin
                image_mode = 1'b1;
                return 1'b0;
            end
            dmpcp_pkg::BYTE_IMAGE_OFF: begin
                image_mode = 1'b0;
                return 1'b0;
            end
            dmpcp_pkg::BYTE_CR, dmpcp_pkg::BYTE_FF: begin
                if (b == dmpcp_pkg::BYTE_CR) begin
                    image_mode = 1'b0;
                    head_x = POS_BITS'(cfg_left);
                    head_y = head_y + POS_BITS'(cfg_spacing);
                    if (head_y < POS_BITS'(cfg_bottom)) return 1'b0;
                end
                head_x = POS_BITS'(cfg_left);
                head_y = POS_BITS'(cfg_top);
                ev.kind = dmpcp_pkg::EV_EJECT;
                ev.x = 16'(head_x);
                ev.y = 16'(head_y);
                return 1'b1;
            end
            default: begin
                ev.x = 16'(head_x);
                ev.y = 16'(head_y);
                if (image_mode) begin
                    ev.kind = dmpcp_pkg::EV_COLUMN;
                    ev.pins = b[6:0];
                    head_x = head_x + POS_BITS'(cfg_step);
                end else begin
                    ev.kind = dmpcp_pkg::EV_CHAR;
                    if ((b >= dmpcp_pkg::UPPER_LO && b <= dmpcp_pkg::UPPER_HI) ||
                        (b >= dmpcp_pkg::PUNCT_LO && b <= dmpcp_pkg::PUNCT_HI))
                        ev.code = b[6:0];
                    else if (b >= dmpcp_pkg::SHIFTED_LO && b <= dmpcp_pkg::SHIFTED_HI)
                        ev.code = lowered[6:0];
                    else
                        ev.code = dmpcp_pkg::ASCII_SPACE;
                    head_x = head_x + POS_BITS'(cfg_advance);
                end
                return 1'b1;
            end
        endcase
    endfunction

    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        end
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endfunction

    // Queues one well-formed command sequence with random content, or a bit of noise.
    function automatic void add_sequence();
        int pick;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 35) begin
            repeat ($urandom_range(12, 1)) begin
                case ($urandom_range(3))
                    0: b = 8'($urandom_range(dmpcp_pkg::UPPER_HI, dmpcp_pkg::UPPER_LO));
                    1: b = 8'($urandom_range(dmpcp_pkg::SHIFTED_HI, dmpcp_pkg::SHIFTED_LO));
                    2: b = 8'($urandom_range(dmpcp_pkg::PUNCT_HI, dmpcp_pkg::PUNCT_LO));
                    default: b = 8'($urandom_range(255));
                endcase
                push_byte(b);
            end
        end else if (pick < 57) begin
            if ($urandom_range(1)) begin
                push_byte(dmpcp_pkg::BYTE_ESC);
                push_byte(dmpcp_pkg::BYTE_ESC_ON);
            end else begin
                push_byte(dmpcp_pkg::BYTE_IMAGE_ON);
            end
            repeat ($urandom_range(16, 1)) begin
                b = 8'($urandom_range(255));
                // Mostly keep column data clear of command codes; now and then let one through.
                if ((b == dmpcp_pkg::BYTE_ESC || b == dmpcp_pkg::BYTE_IMAGE_ON ||
                     b == dmpcp_pkg::BYTE_IMAGE_OFF || b == dmpcp_pkg::BYTE_CR ||
                     b == dmpcp_pkg::BYTE_FF) && $urandom_range(9) != 0)
                    b[7] = 1'b1;
                push_byte(b);
            end
            case ($urandom_range(2))
                0: begin
                    push_byte(dmpcp_pkg::BYTE_ESC);
                    push_byte(dmpcp_pkg::BYTE_ESC_OFF);
                end
                1: push_byte(dmpcp_pkg::BYTE_IMAGE_OFF);
                default: push_byte(dmpcp_pkg::BYTE_CR);
            endcase
        end else if (pick < 72) begin
            repeat ($urandom_range(3, 1)) push_byte(dmpcp_pkg::BYTE_CR);
        end else if (pick < 77) begin
            push_byte(dmpcp_pkg::BYTE_FF);
        end else if (pick < 87) begin
            push_byte(dmpcp_pkg::BYTE_ESC);
            push_byte(8'($urandom_range(255)));
        end else begin
            push_byte(8'($urandom_range(255)));
        end
    endfunction

    // Sender: offers queued bytes and predicts the outcome of each accepted one.
    always @(posedge clk or negedge rst_n)
    begin : byte_sender
        dmpcp_pkg::result_t ev;
        if (!rst_n) begin
            in_valid <= 1'b0;
            data_byte <= 8'h00;
        end else begin
            if (in_valid && !in_stall) begin
                bytes_accepted++;
                if (printer_step(data_byte, ev))
                    expected_events.push_back(ev);
            end
            if (!in_valid || !in_stall) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    data_byte <= pending_bytes.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls at random and compares each accepted event with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : event_checker
        dmpcp_pkg::result_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
            if (out_valid && !out_stall) begin
                if (expected_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 40)
                        $display("%0t: event expected none actual kind %0d x %0h y %0h",
                                 $time, event_kind, pos_x, pos_y);
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_kind", 16'(want.kind), 16'(event_kind));
                    check_field("char_code", 16'(want.code), 16'(char_code));
                    check_field("pin_mask", 16'(want.pins), 16'(pin_mask));
                    check_field("pos_x", want.x, pos_x);
                    check_field("pos_y", want.y, pos_y);
                    case (want.kind)
                        dmpcp_pkg::EV_CHAR: chars_seen++;
                        dmpcp_pkg::EV_COLUMN: columns_seen++;
                        default: ejects_seen++;
                    endcase
                end
            end
        end
    end

    // Waits until every byte is in and every event is out, then lets the block settle.
    task automatic drain();
        while (pending_bytes.size() != 0 || in_valid || expected_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [IDX_BITS-1:0] idx,
                             input logic [dmpcp_pkg::CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            dmpcp_pkg::CFG_LEFT_MARGIN:  cfg_left = val;
            dmpcp_pkg::CFG_BOTTOM_LIMIT: cfg_bottom = val;
            dmpcp_pkg::CFG_LINE_SPACING: cfg_spacing = val[11:0];
            dmpcp_pkg::CFG_COLUMN_STEP:  cfg_step = val[4:0];
            dmpcp_pkg::CFG_CHAR_ADVANCE: cfg_advance = val[6:0];
            dmpcp_pkg::CFG_TOP_OF_PAGE:  cfg_top = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] left, input logic [15:0] bottom,
                                  input logic [15:0] spacing, input logic [15:0] step,
                                  input logic [15:0] advance, input logic [15:0] top);
        cfg_write(dmpcp_pkg::CFG_LEFT_MARGIN, left);
        cfg_write(dmpcp_pkg::CFG_BOTTOM_LIMIT, bottom);
        cfg_write(dmpcp_pkg::CFG_LINE_SPACING, spacing);
        cfg_write(dmpcp_pkg::CFG_COLUMN_STEP, step);
        cfg_write(dmpcp_pkg::CFG_CHAR_ADVANCE, advance);
        cfg_write(dmpcp_pkg::CFG_TOP_OF_PAGE, top);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random(input int count);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < count)
            add_sequence();
        drain();
    endtask

    // Register values drawn from the legal ranges, with the bottom limit kept near the
    // top of page so that carriage returns eject pages often.
    task automatic random_settings();
        logic [15:0] top;
        top = 16'($urandom_range(65535));
        apply_settings(16'($urandom_range(65535)), top + 16'($urandom_range(400)),
                       16'($urandom_range(100, 1)), 16'($urandom_range(16, 1)),
                       16'($urandom_range(96, 6)), top);
    endtask

    initial
    begin
        esc_armed = 1'b0;
        image_mode = 1'b0;
        cfg_left = dmpcp_pkg::LEFT_MARGIN_RST;
        cfg_bottom = dmpcp_pkg::BOTTOM_LIMIT_RST;
        cfg_spacing = dmpcp_pkg::LINE_SPACING_RST;
        cfg_step = dmpcp_pkg::COLUMN_STEP_RST;
        cfg_advance = dmpcp_pkg::CHAR_ADVANCE_RST;
        cfg_top = dmpcp_pkg::TOP_OF_PAGE_RST;
        head_x = POS_BITS'(dmpcp_pkg::LEFT_MARGIN_RST);
        head_y = POS_BITS'(dmpcp_pkg::TOP_OF_PAGE_RST);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: mapping range edges, both ways into and out of bit-image mode,
        // a dropped byte after ESC, a carriage return that ends bit-image mode, form feed.
        send_idle_pct = 38;
        recv_idle_pct = 80;
        push_byte(dmpcp_pkg::UPPER_LO);
        push_byte(dmpcp_pkg::UPPER_HI);
        push_byte(dmpcp_pkg::SHIFTED_LO);
        push_byte(dmpcp_pkg::SHIFTED_HI);
        push_byte(dmpcp_pkg::PUNCT_LO);
        push_byte(dmpcp_pkg::PUNCT_HI);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(dmpcp_pkg::SHIFTED_OFFSET);
        push_byte(8'hDB);
        push_byte(dmpcp_pkg::BYTE_ESC);
        push_byte(dmpcp_pkg::BYTE_ESC_ON);
        push_byte(8'h7F);
        push_byte(8'h80);
        push_byte(dmpcp_pkg::BYTE_ESC);
        push_byte(dmpcp_pkg::BYTE_ESC_OFF);
        push_byte(dmpcp_pkg::BYTE_IMAGE_ON);
        push_byte(8'h55);
        push_byte(dmpcp_pkg::BYTE_CR);
        push_byte(8'h2A);
        push_byte(dmpcp_pkg::BYTE_IMAGE_OFF);
        push_byte(dmpcp_pkg::BYTE_ESC);
        push_byte(dmpcp_pkg::BYTE_ESC);
        push_byte(dmpcp_pkg::UPPER_LO);
        push_byte(dmpcp_pkg::BYTE_FF);
        drain();

        run_random(230);
        apply_settings(16'hFFFF, 16'h0000, 16'd4095, 16'd16, 16'd96, 16'hFFFF);
        run_random(230);

        send_idle_pct = 80;
        recv_idle_pct = 38;
        apply_settings(16'h0000, 16'hFFFF, 16'd0, 16'd1, 16'd6, 16'h0000);
        run_random(230);
        random_settings();
        run_random(230);

        // Raw writes to every index, including ones past the register list and values
        // outside the documented ranges such as a zero column step.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 2 ** IDX_BITS; i++)
            cfg_write(IDX_BITS'(i), 16'($urandom_range(65535)));
        cfg_write(dmpcp_pkg::CFG_COLUMN_STEP, 16'd0);
        cfg_write(dmpcp_pkg::CFG_BOTTOM_LIMIT, cfg_top + 16'($urandom_range(300)));
        @(posedge clk);
        cfg_write_en <= 1'b0;
        settings_used++;
        run_random(230);
        random_settings();
        run_random(230);

        repeat (10) @(posedge clk);
        $display("tb: %0d bytes accepted over %0d register settings", bytes_accepted,
                 settings_used);
        $display("tb: checked %0d characters, %0d image columns, %0d page ejects",
                 chars_seen, columns_seen, ejects_seen);
        if (mismatches == 0 && expected_events.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/dmpcp_pkg.sv
design/dot_matrix_printer_command_parser.sv
tb/tb_dot_matrix_printer_command_parser.sv
